// File: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// Decimal seven-segment scanner package
// Shared widths, the controller state type and the segment decode table.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int SEL_WIDTH   = 3;
    localparam int SEG_WIDTH   = 7;
    localparam int BCD_WIDTH   = 4;
    localparam int BITC_WIDTH  = $clog2(VALUE_WIDTH);

    typedef logic [SEL_WIDTH-1:0] sel_t;
    typedef logic [SEG_WIDTH-1:0] seg_t;
    typedef logic [BCD_WIDTH-1:0] bcd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT
    } state_t;

    localparam int NUM_PATTERNS = 10;

    function automatic seg_t seg_decode(bcd_t digit);
        seg_t pattern;
        unique case (digit)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h6F;
            default: pattern = 7'h3F;
        endcase
        return pattern;
    endfunction

endpackage

// File: rtl/decimal_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// Decimal seven-segment scanner
// Converts the display value to decimal digits and emits one digit per request.
// ----------------------------------------------------------------------------
// Usage:
// Writing display_value (display_value_we high for one cycle) starts a
// conversion to NUM_DIGITS decimal digits, which keeps the value modulo
// 10^NUM_DIGITS. The conversion shifts the value in one bit per cycle
// through a BCD shift register (ST_CONV), then counts the significant
// digits (ST_COUNT); in_stall is high during both states. The scan
// restarts at the least significant digit.
// Each request on the input channel (in_valid, in_stall, advance)
// yields one result on the output channel (out_valid, out_stall,
// digit_select, segments) in the following cycle, and a new request is
// taken every cycle while in_stall is low. The single-stage output
// register means a stalled result holds the input channel stalled too.
// Reset clears the digits to a single 0 shown at position 7.
// ----------------------------------------------------------------------------
module decimal_seven_segment_scanner #(
    parameter int NUM_DIGITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            display_value_we,
    input  logic [dss_pkg::VALUE_WIDTH-1:0] display_value,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            advance,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dss_pkg::SEL_WIDTH-1:0]   digit_select,
    output logic [dss_pkg::SEG_WIDTH-1:0]   segments
);

    localparam int STORE_WIDTH = NUM_DIGITS * dss_pkg::BCD_WIDTH;
    localparam int IDX_WIDTH   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CNT_WIDTH   = $clog2(NUM_DIGITS + 1);
    localparam dss_pkg::sel_t LAST_SEL = dss_pkg::SEL_WIDTH'((NUM_DIGITS - 1) % 8);

    dss_pkg::state_t                  state_reg, state_next;
    logic [dss_pkg::VALUE_WIDTH-1:0]  bin_reg, bin_next;
    logic [STORE_WIDTH-1:0]           bcd_reg, bcd_next;
    logic [STORE_WIDTH-1:0]           bcd_adj;
    logic [dss_pkg::BITC_WIDTH-1:0]   bitc_reg, bitc_next;
    logic [CNT_WIDTH-1:0]             count_reg, count_next;
    logic [CNT_WIDTH-1:0]             count_found;
    logic [IDX_WIDTH-1:0]             idx_reg, idx_next;
    logic [CNT_WIDTH-1:0]             idx_inc;
    logic                             out_valid_reg, out_valid_next;
    dss_pkg::sel_t                    sel_reg, sel_next;
    dss_pkg::seg_t                    seg_reg, seg_next;
    dss_pkg::bcd_t                    cur_digit;
    logic                             in_accept;

    assign in_stall  = (state_reg != dss_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign cur_digit = bcd_reg[idx_reg * dss_pkg::BCD_WIDTH +: dss_pkg::BCD_WIDTH];
    assign idx_inc   = CNT_WIDTH'(idx_reg) + CNT_WIDTH'(1);

    // Each digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        count_found = CNT_WIDTH'(1);
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
                count_found = CNT_WIDTH'(i + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dss_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bitc_next      = bitc_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        seg_next       = seg_reg;

        unique case (state_reg)
            dss_pkg::ST_IDLE:
            begin
            end
            dss_pkg::ST_CONV:
            begin
                bcd_next  = {bcd_adj[STORE_WIDTH-2:0], bin_reg[dss_pkg::VALUE_WIDTH-1]};
                bin_next  = {bin_reg[dss_pkg::VALUE_WIDTH-2:0], 1'b0};
                bitc_next = bitc_reg + dss_pkg::BITC_WIDTH'(1);
                if (bitc_reg == dss_pkg::BITC_WIDTH'(dss_pkg::VALUE_WIDTH - 1))
                    state_next = dss_pkg::ST_COUNT;
            end
            dss_pkg::ST_COUNT:
            begin
                count_next = count_found;
                state_next = dss_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dss_pkg::ST_IDLE;
            end
        endcase

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (in_accept)
        begin
            out_valid_next = 1'b1;
            sel_next       = LAST_SEL - dss_pkg::SEL_WIDTH'(idx_reg);
            seg_next       = dss_pkg::seg_decode(cur_digit);
            if (advance)
            begin
                if (idx_inc >= count_reg)
                    idx_next = '0;
                else
                    idx_next = idx_inc[IDX_WIDTH-1:0];
            end
        end

        if (display_value_we)
        begin
            bin_next   = display_value;
            bcd_next   = '0;
            bitc_next  = '0;
            idx_next   = '0;
            state_next = dss_pkg::ST_CONV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg       <= '0;
            bitc_reg      <= '0;
            count_reg     <= CNT_WIDTH'(1);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bcd_reg       <= bcd_next;
            bitc_reg      <= bitc_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        sel_reg <= sel_next;
        seg_reg <= seg_next;
    end

    assign out_valid    = out_valid_reg;
    assign digit_select = sel_reg;
    assign segments     = seg_reg;

endmodule

// File: rtl/dss_checker.sv
// ----------------------------------------------------------------------------
// Decimal seven-segment scanner checker
// Port-level assertions on the scanner, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module dss_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            display_value_we,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [dss_pkg::SEL_WIDTH-1:0]   digit_select,
    input logic [dss_pkg::SEG_WIDTH-1:0]   segments
);

    logic seg_ok;

    always_comb
    begin
        seg_ok = 1'b0;
        for (int i = 0; i < dss_pkg::NUM_PATTERNS; i++)
        begin
            if (segments == dss_pkg::seg_decode(dss_pkg::BCD_WIDTH'(i)))
                seg_ok = 1'b1;
        end
    end

    // A new value keeps requests out while its digits are converted.
    assert property (@(posedge clk) disable iff (!rst_n)
        display_value_we |=> in_stall)
        else $error("request accepted right after a value write");

    // Every accepted request produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted request produced no result");

    // A shown result always carries a decimal digit pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seg_ok)
        else $error("segment pattern is not a decimal digit");

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(digit_select) && $stable(segments)))
        else $error("stalled result changed");

    // Requests are taken only while a result is free to leave.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("request taken while the result is stalled");

endmodule

bind decimal_seven_segment_scanner dss_checker u_dss_checker (.*);
